// File: design/pchg_pkg.sv
// Package for the point cloud height grid: payload types, status codes and register indexes.
package pchg_pkg;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_ROT_ROW_X     = 3'd0;
    localparam logic [2:0] REG_ROT_ROW_Y     = 3'd1;
    localparam logic [2:0] REG_ROT_ROW_Z     = 3'd2;
    localparam logic [2:0] REG_OFFSET_XYZ    = 3'd3;
    localparam logic [2:0] REG_REGION_HALF   = 3'd4;
    localparam logic [2:0] REG_CELLS_PER_M   = 3'd5;
    localparam logic [2:0] REG_Z_FLOOR       = 3'd6;
    localparam logic [2:0] REG_Z_SCALE       = 3'd7;

    // Result status codes.
    localparam logic [1:0] STATUS_FUSED   = 2'd0;
    localparam logic [1:0] STATUS_OUTSIDE = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;
    localparam logic [1:0] STATUS_READ    = 2'd3;

    // Request type codes.
    localparam logic REQ_FUSE = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Widest grid address and cell value that the memory port carries.
    localparam int MAX_ADDR_W = 20;
    localparam int MAX_DATA_W = 16;

    typedef struct packed {
        logic               req_type;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] point_z;
        logic               point_valid;
        logic [6:0]         cell_row;
        logic [6:0]         cell_col;
    } pchg_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] out_row;
        logic [6:0] out_col;
        logic [7:0] out_height;
    } pchg_out_t;

    // One access to the grid memory: read and write requests.
    typedef struct packed {
        logic                  re;
        logic [MAX_ADDR_W-1:0] raddr;
        logic                  we;
        logic [MAX_ADDR_W-1:0] waddr;
        logic [MAX_DATA_W-1:0] wdata;
    } pchg_mem_req_t;

endpackage

// File: design/pchg_grid_ram.sv
// Single-port-per-direction grid memory with a registered read.
module pchg_grid_ram
    import pchg_pkg::*;
#(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14,
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  pchg_mem_req_t     req,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr[ADDR_W-1:0]] <= req.wdata[DATA_W-1:0];
        end
    end

    // Read port, registered.
    always_ff @(posedge aclk) begin
        if (req.re) begin
            rdata_reg <= mem[req.raddr[ADDR_W-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/point_cloud_height_grid.sv
// Point cloud height grid top: transform, binning, height scaling, max fusion and read-clear.
//
//  Channel   Ports                        Direction  Moves
//  input     s_valid s_ready s_payload    in         fuse or read-and-clear request
//  result    m_valid m_ready m_payload    out        one result per request
//  config    cfg_we cfg_index cfg_wdata   in         register write, no wait
//
// A fuse request runs the X, Y and Z rows through the shared row multiply-add, then one
// region check, two multiply stages and one grid memory read before the write-back; a
// point outside the region goes from the check to write-back. A read request does one grid
// memory read first; an invalid point goes straight to write-back. After reset the grid
// is cleared one cell a cycle, and no request is taken meanwhile nor before the last one
// has left write-back. A result waiting in the output register stalls only the next write-back.
module point_cloud_height_grid
    import pchg_pkg::*;
#(
    parameter int GRID_ROWS   = 128,
    parameter int GRID_COLS   = 128,
    parameter int HEIGHT_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  pchg_in_t    s_payload,
    output logic        m_valid,
    input  logic        m_ready,
    output pchg_out_t   m_payload,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_wdata
);

    localparam int DEPTH  = GRID_ROWS * GRID_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ROW_W  = $clog2(GRID_ROWS);
    localparam int COL_W  = $clog2(GRID_COLS);
    localparam logic [15:0] HMAX = 16'((1 << HEIGHT_BITS) - 1);
    localparam logic [36:0] ONE_Q36 = 37'h1 << 36;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_ROW   = 4'd2;
    localparam logic [3:0] ST_CHECK = 4'd3;
    localparam logic [3:0] ST_MUL   = 4'd4;
    localparam logic [3:0] ST_SCALE = 4'd5;
    localparam logic [3:0] ST_RD    = 4'd6;
    localparam logic [3:0] ST_WB    = 4'd7;

    // Configuration registers.
    logic [47:0] rot_x_reg, rot_y_reg, rot_z_reg, offset_reg;
    logic [31:0] half_reg, cpm_reg;
    logic [15:0] z_floor_reg, z_scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_x_reg   <= 48'd16384;
            rot_y_reg   <= 48'd16384 << 16;
            rot_z_reg   <= 48'd16384 << 32;
            offset_reg  <= 48'd0;
            half_reg    <= 32'h0C00_0C00;
            cpm_reg     <= 32'd360454656;
            z_floor_reg <= 16'hFC00;
            z_scale_reg <= 16'd2048;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ROT_ROW_X:   rot_x_reg   <= cfg_wdata;
                REG_ROT_ROW_Y:   rot_y_reg   <= cfg_wdata;
                REG_ROT_ROW_Z:   rot_z_reg   <= cfg_wdata;
                REG_OFFSET_XYZ:  offset_reg  <= cfg_wdata;
                REG_REGION_HALF: half_reg    <= cfg_wdata[31:0];
                REG_CELLS_PER_M: cpm_reg     <= cfg_wdata[31:0];
                REG_Z_FLOOR:     z_floor_reg <= cfg_wdata[15:0];
                REG_Z_SCALE:     z_scale_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Control state.
    logic [3:0]        state_reg, state_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic              m_valid_reg, m_valid_next;

    // Datapath registers.
    pchg_in_t               in_reg;
    logic signed [35:0]     wx_reg, wy_reg, wz_reg;
    logic [30:0]            span_x_reg, span_y_reg;
    logic signed [36:0]     diff_reg;
    logic [46:0]            colp_reg, rowp_reg;
    logic signed [53:0]     fprod_reg;
    logic [52:0]            hprod_reg;
    logic [ROW_W-1:0]       row_reg;
    logic [COL_W-1:0]       col_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic [HEIGHT_BITS-1:0] hval_reg;
    logic [1:0]             kind_reg;
    pchg_out_t              m_data_reg;

    pchg_mem_req_t          mem_req;
    logic [HEIGHT_BITS-1:0] mem_rdata;

    // Shared row multiply-add: one rotation row and offset lane per cycle.
    logic [47:0]        row_sel;
    logic [15:0]        off_sel;
    logic signed [31:0] p0, p1, p2;
    logic signed [35:0] row_sum;

    always_comb begin
        case (cnt_reg)
            2'd0:    begin row_sel = rot_x_reg; off_sel = offset_reg[15:0];  end
            2'd1:    begin row_sel = rot_y_reg; off_sel = offset_reg[31:16]; end
            default: begin row_sel = rot_z_reg; off_sel = offset_reg[47:32]; end
        endcase
        p0 = $signed(row_sel[15:0])  * in_reg.point_x;
        p1 = $signed(row_sel[31:16]) * in_reg.point_y;
        p2 = $signed(row_sel[47:32]) * in_reg.point_z;
        row_sum = 36'(p0) + 36'(p1) + 36'(p2) + $signed({{6{off_sel[15]}}, off_sel, 14'b0});
    end

    // Region bounds and offsets from the floor.
    logic signed [35:0] hx, hy, sx_full, sy_full;
    logic signed [36:0] zfl;
    logic               in_region;

    always_comb begin
        hx = $signed({6'b0, half_reg[15:0], 14'b0});
        hy = $signed({6'b0, half_reg[31:16], 14'b0});
        in_region = (wx_reg >= -hx) && (wx_reg < hx) && (wy_reg >= -hy) && (wy_reg < hy);
        sx_full = wx_reg + hx;
        sy_full = wy_reg + hy;
        zfl = $signed({{7{z_floor_reg[15]}}, z_floor_reg, 14'b0});
    end

    // Clamping of cell indexes and of the height fraction.
    logic [15:0]      col_idx, row_idx;
    logic [COL_W-1:0] col_clamp;
    logic [ROW_W-1:0] row_clamp;
    logic [36:0]      frac;
    logic [53:0]      hround;

    always_comb begin
        col_idx = {1'b0, colp_reg[46:32]};
        row_idx = {1'b0, rowp_reg[46:32]};
        col_clamp = (col_idx >= 16'(GRID_COLS)) ? COL_W'(GRID_COLS - 1) : COL_W'(col_idx);
        row_clamp = (row_idx >= 16'(GRID_ROWS)) ? ROW_W'(GRID_ROWS - 1) : ROW_W'(row_idx);
        if (fprod_reg[53]) begin
            frac = '0;
        end else if (fprod_reg[52:0] > 53'(ONE_Q36)) begin
            frac = ONE_Q36;
        end else begin
            frac = fprod_reg[36:0];
        end
        hround = 54'(hprod_reg) + (54'd1 << 35);
    end

    // Read requests saturate to the last row and column.
    logic [ROW_W-1:0] rd_row;
    logic [COL_W-1:0] rd_col;

    always_comb begin
        rd_row = (16'(s_payload.cell_row) >= 16'(GRID_ROWS)) ? ROW_W'(GRID_ROWS - 1)
                                                             : ROW_W'(s_payload.cell_row);
        rd_col = (16'(s_payload.cell_col) >= 16'(GRID_COLS)) ? COL_W'(GRID_COLS - 1)
                                                             : COL_W'(s_payload.cell_col);
    end

    // Sequencer.
    logic s_fire, wb_go;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign wb_go   = (state_reg == ST_WB) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        clr_next     = clr_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                cnt_next = 2'd0;
                if (s_fire) begin
                    if (s_payload.req_type == REQ_READ) begin
                        state_next = ST_RD;
                    end else if (!s_payload.point_valid) begin
                        state_next = ST_WB;
                    end else begin
                        state_next = ST_ROW;
                    end
                end
            end
            ST_ROW: begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd2) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: state_next = in_region ? ST_MUL : ST_WB;
            ST_MUL:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_RD;
            ST_RD:    state_next = ST_WB;
            ST_WB: begin
                if (wb_go) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cnt_reg     <= 2'd0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath stages.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_reg   <= s_payload;
            row_reg  <= rd_row;
            col_reg  <= rd_col;
            addr_reg <= ADDR_W'(ADDR_W'(rd_row) * ADDR_W'(GRID_COLS) + ADDR_W'(rd_col));
            if (s_payload.req_type == REQ_READ) begin
                kind_reg <= STATUS_READ;
            end else begin
                kind_reg <= STATUS_INVALID;
            end
        end
        if (state_reg == ST_ROW) begin
            case (cnt_reg)
                2'd0:    wx_reg <= row_sum;
                2'd1:    wy_reg <= row_sum;
                default: wz_reg <= row_sum;
            endcase
        end
        if (state_reg == ST_CHECK) begin
            span_x_reg <= sx_full[30:0];
            span_y_reg <= sy_full[30:0];
            diff_reg   <= 37'(wz_reg) - zfl;
            kind_reg   <= in_region ? STATUS_FUSED : STATUS_OUTSIDE;
        end
        if (state_reg == ST_MUL) begin
            colp_reg  <= 47'(span_x_reg) * 47'(cpm_reg[15:0]);
            rowp_reg  <= 47'(span_y_reg) * 47'(cpm_reg[31:16]);
            fprod_reg <= diff_reg * $signed({1'b0, z_scale_reg});
        end
        if (state_reg == ST_SCALE) begin
            hprod_reg <= 53'(frac) * 53'(HMAX);
            row_reg   <= row_clamp;
            col_reg   <= col_clamp;
            addr_reg  <= ADDR_W'(ADDR_W'(row_clamp) * ADDR_W'(GRID_COLS) + ADDR_W'(col_clamp));
        end
        if (state_reg == ST_RD && kind_reg == STATUS_FUSED) begin
            hval_reg <= HEIGHT_BITS'(hround[53:36]);
        end
    end

    // Result register: rejected points report zero row, column and height.
    always_ff @(posedge aclk) begin
        if (wb_go) begin
            m_data_reg.status <= kind_reg;
            if (kind_reg == STATUS_FUSED || kind_reg == STATUS_READ) begin
                m_data_reg.out_row    <= 7'(row_reg);
                m_data_reg.out_col    <= 7'(col_reg);
                m_data_reg.out_height <= (kind_reg == STATUS_READ) ? 8'(mem_rdata)
                                                                   : 8'(hval_reg);
            end else begin
                m_data_reg.out_row    <= 7'd0;
                m_data_reg.out_col    <= 7'd0;
                m_data_reg.out_height <= 8'd0;
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_data_reg;

    // Grid memory access: clearing sweep, lookup, and at write-back a clear or max update.
    always_comb begin
        mem_req       = '0;
        mem_req.re    = (state_reg == ST_RD);
        mem_req.raddr = MAX_ADDR_W'(addr_reg);
        if (state_reg == ST_CLEAR) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = MAX_ADDR_W'(clr_reg);
        end else if (wb_go && kind_reg == STATUS_READ) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = MAX_ADDR_W'(addr_reg);
        end else if (wb_go && kind_reg == STATUS_FUSED && hval_reg > mem_rdata) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = MAX_ADDR_W'(addr_reg);
            mem_req.wdata = MAX_DATA_W'(hval_reg);
        end
    end

    pchg_grid_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (HEIGHT_BITS)
    ) u_grid (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // A new result only appears out of the write-back state.
    a_result_from_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_WB)
        else $error("result raised outside write-back");

    // The grid is written only while clearing or at write-back.
    a_write_window: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.we |-> (state_reg == ST_CLEAR || state_reg == ST_WB))
        else $error("grid written outside its window");

    // Rejected points carry zero cell and height.
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg.status == STATUS_OUTSIDE ||
                         m_data_reg.status == STATUS_INVALID))
        |-> (m_data_reg.out_row == 7'd0 && m_data_reg.out_col == 7'd0 &&
             m_data_reg.out_height == 8'd0))
        else $error("rejected point reports a cell");

endmodule

// File: tb/point_cloud_height_grid_tb.sv
// Testbench for the point cloud height grid: directed table, then random traffic checked against a predictor.
module point_cloud_height_grid_tb;
    import pchg_pkg::*;

    localparam int ROWS = 128;
    localparam int COLS = 128;
    localparam int HMAX = 255;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    pchg_in_t    s_payload;
    logic        m_valid;
    logic        m_ready;
    pchg_out_t   m_payload;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_wdata;

    point_cloud_height_grid u_dut (.*);

    // Predictor state: configuration copy and grid copy.
    logic [47:0] rot_x, rot_y, rot_z, offs;
    logic [31:0] half_reg, cpm_reg;
    logic [15:0] zfloor_reg, zscale_reg;
    logic [7:0]  grid_copy [ROWS*COLS];

    pchg_out_t   pending_results [$];
    int          error_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off_cycles;

    // Directed table row with an optional typed-in result.
    typedef struct {
        pchg_in_t  req;
        bit        known;
        pchg_out_t res;
    } table_row_t;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #40000000;
        $display("Verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic longint lane_of(input logic [47:0] r, input int k);
        logic signed [15:0] v;
        v = r[16*k +: 16];
        return longint'(v);
    endfunction

    function automatic longint row_dot(input logic [47:0] r, input int k,
                                       input longint px, input longint py, input longint pz);
        return lane_of(r, 0) * px + lane_of(r, 1) * py + lane_of(r, 2) * pz
               + lane_of(offs, k) * 16384;
    endfunction

    function automatic int cell_index(input longint pos, input longint half,
                                      input longint cpm, input int limit);
        logic [63:0] prod;
        longint idx;
        prod = 64'(pos + half) * 64'(cpm);
        idx = longint'(prod >> 32);
        return (idx >= limit) ? limit - 1 : int'(idx);
    endfunction

    // Computes the result of one request and updates the grid copy.
    function automatic pchg_out_t predict_cell_update(input pchg_in_t q);
        pchg_out_t o;
        longint px, py, pz, wx, wy, wz, hx, hy, frac, rr, cc;
        logic [63:0] hv;
        o = '0;
        if (q.req_type == REQ_READ) begin
            rr = q.cell_row;
            cc = q.cell_col;
            o.status = STATUS_READ;
            o.out_row = rr[6:0];
            o.out_col = cc[6:0];
            o.out_height = grid_copy[rr*COLS + cc];
            grid_copy[rr*COLS + cc] = '0;
        end else if (!q.point_valid) begin
            o.status = STATUS_INVALID;
        end else begin
            px = q.point_x; py = q.point_y; pz = q.point_z;
            wx = row_dot(rot_x, 0, px, py, pz);
            wy = row_dot(rot_y, 1, px, py, pz);
            wz = row_dot(rot_z, 2, px, py, pz);
            hx = longint'(half_reg[15:0]) * 16384;
            hy = longint'(half_reg[31:16]) * 16384;
            if (!(wx >= -hx && wx < hx && wy >= -hy && wy < hy)) begin
                o.status = STATUS_OUTSIDE;
            end else begin
                cc = cell_index(wx, hx, cpm_reg[15:0], COLS);
                rr = cell_index(wy, hy, cpm_reg[31:16], ROWS);
                frac = (wz - lane_of({32'd0, zfloor_reg}, 0) * 16384) * longint'(zscale_reg);
                if (frac < 0) frac = 0;
                else if (frac > (64'sd1 <<< 36)) frac = 64'sd1 <<< 36;
                hv = (64'(frac) * HMAX + (64'd1 << 35)) >> 36;
                o.status = STATUS_FUSED;
                o.out_row = rr[6:0];
                o.out_col = cc[6:0];
                o.out_height = hv[7:0];
                if (hv[7:0] > grid_copy[rr*COLS + cc]) grid_copy[rr*COLS + cc] = hv[7:0];
            end
        end
        return o;
    endfunction

    task automatic reset_predictor();
        rot_x = 48'd16384;
        rot_y = 48'd16384 << 16;
        rot_z = 48'd16384 << 32;
        offs = '0;
        half_reg = 32'h0C000C00;
        cpm_reg = 32'd360454656;
        zfloor_reg = 16'hFC00;
        zscale_reg = 16'd2048;
        foreach (grid_copy[i]) grid_copy[i] = '0;
    endtask

    // Register write, mirrored into the predictor; the enable drops again after the write.
    task automatic write_register(input logic [2:0] idx, input logic [47:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ROT_ROW_X:   rot_x = val;
            REG_ROT_ROW_Y:   rot_y = val;
            REG_ROT_ROW_Z:   rot_z = val;
            REG_OFFSET_XYZ:  offs = val;
            REG_REGION_HALF: half_reg = val[31:0];
            REG_CELLS_PER_M: cpm_reg = val[31:0];
            REG_Z_FLOOR:     zfloor_reg = val[15:0];
            REG_Z_SCALE:     zscale_reg = val[15:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Stops offering, waits until every expected result has arrived, then lets the
    // pipeline drain.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // One transfer on the input channel, with random idle cycles before it.
    task automatic send_request(input pchg_in_t q, input bit known, input pchg_out_t res);
        pchg_out_t want;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= q;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        want = predict_cell_update(q);
        if (known && want != res) report_mismatch("table entry", res, want);
        pending_results.push_back(want);
    endtask

    function automatic pchg_in_t random_request(input int read_pct);
        pchg_in_t q;
        q = pchg_in_t'({$urandom, $urandom});
        q.req_type = ($urandom_range(99) < read_pct) ? REQ_READ : REQ_FUSE;
        q.point_valid = ($urandom_range(99) < 90);
        // Mostly points near the region so that they are fused.
        if ($urandom_range(99) < 80) begin
            q.point_x = 16'($signed($urandom_range(0, 8191)) - 4096);
            q.point_y = 16'($signed($urandom_range(0, 8191)) - 4096);
            q.point_z = 16'($signed($urandom_range(0, 8191)) - 4096);
        end
        return q;
    endfunction

    function automatic pchg_in_t make_req(input logic rt, input int x, input int y,
                                          input int z, input logic v,
                                          input int r, input int c);
        pchg_in_t q;
        q.req_type = rt;
        q.point_x = 16'(x);
        q.point_y = 16'(y);
        q.point_z = 16'(z);
        q.point_valid = v;
        q.cell_row = 7'(r);
        q.cell_col = 7'(c);
        return q;
    endfunction

    function automatic pchg_out_t make_res(input logic [1:0] st, input int r, input int c,
                                           input int h);
        pchg_out_t o;
        o.status = st;
        o.out_row = 7'(r);
        o.out_col = 7'(c);
        o.out_height = 8'(h);
        return o;
    endfunction

    // Result checking against the oldest expectation.
    always @(posedge aclk) begin
        pchg_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", m_payload, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_payload.status != want.status)
                    report_mismatch("status", m_payload.status, want.status);
                if (m_payload.out_row != want.out_row)
                    report_mismatch("out_row", m_payload.out_row, want.out_row);
                if (m_payload.out_col != want.out_col)
                    report_mismatch("out_col", m_payload.out_col, want.out_col);
                if (m_payload.out_height != want.out_height)
                    report_mismatch("out_height", m_payload.out_height, want.out_height);
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(posedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        table_row_t rows [$];
        pchg_out_t  none;
        int         n;
        none = '0;
        error_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_payload = '0;
        m_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_ROT_ROW_X;
        cfg_wdata = '0;
        reset_predictor();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table, default configuration (identity, half 3 m, 26 cells/m in x, 21.5 in y).
        rows.push_back('{make_req(REQ_READ, 0, 0, 0, 1, 0, 0), 1, make_res(STATUS_READ, 0, 0, 0)});
        rows.push_back('{make_req(REQ_READ, 0, 0, 0, 0, 127, 127), 1,
                         make_res(STATUS_READ, 127, 127, 0)});
        rows.push_back('{make_req(REQ_FUSE, 0, 0, 0, 0, 5, 5), 1,
                         make_res(STATUS_INVALID, 0, 0, 0)});
        rows.push_back('{make_req(REQ_FUSE, 32767, 0, 0, 1, 0, 0), 1,
                         make_res(STATUS_OUTSIDE, 0, 0, 0)});
        rows.push_back('{make_req(REQ_FUSE, -32768, -32768, -32768, 1, 0, 0), 1,
                         make_res(STATUS_OUTSIDE, 0, 0, 0)});
        rows.push_back('{make_req(REQ_FUSE, 0, 3072, 0, 1, 0, 0), 1,
                         make_res(STATUS_OUTSIDE, 0, 0, 0)});
        rows.push_back('{make_req(REQ_FUSE, -3072, -3072, -32768, 1, 0, 0), 0, none});
        rows.push_back('{make_req(REQ_FUSE, 3071, 3071, 32767, 1, 0, 0), 0, none});
        rows.push_back('{make_req(REQ_FUSE, 0, 0, 0, 1, 0, 0), 0, none});
        rows.push_back('{make_req(REQ_FUSE, 0, 0, 512, 1, 0, 0), 0, none});
        rows.push_back('{make_req(REQ_FUSE, 0, 0, -100, 1, 0, 0), 0, none});
        rows.push_back('{make_req(REQ_READ, 0, 0, 0, 1, 64, 64), 0, none});
        rows.push_back('{make_req(REQ_READ, 0, 0, 0, 1, 64, 64), 1,
                         make_res(STATUS_READ, 64, 64, 0)});
        rows.push_back('{make_req(REQ_READ, 0, 0, 0, 0, 0, 0), 0, none});
        rows.push_back('{make_req(REQ_READ, -1, -1, -1, 1, 127, 127), 0, none});
        foreach (rows[i]) send_request(rows[i].req, rows[i].known, rows[i].res);
        wait_idle();

        // Zero region half: every valid point is outside.
        write_register(REG_REGION_HALF, 48'd0);
        for (int i = 0; i < 4; i++) send_request(random_request(0), 0, none);
        wait_idle();

        // Random phases over several configurations and idling patterns.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_register(REG_ROT_ROW_X, 48'd16384);
                    write_register(REG_ROT_ROW_Y, 48'd16384 << 16);
                    write_register(REG_ROT_ROW_Z, 48'd16384 << 32);
                    write_register(REG_OFFSET_XYZ, 48'd0);
                    write_register(REG_REGION_HALF, 48'h0C000C00);
                    write_register(REG_CELLS_PER_M, 48'd360454656);
                    write_register(REG_Z_FLOOR, 48'hFC00);
                    write_register(REG_Z_SCALE, 48'd2048);
                    send_idle_pct = 0; recv_stall_pct = 0;
                end
                1: begin
                    write_register(REG_REGION_HALF, 48'hFFFFFFFF);
                    write_register(REG_CELLS_PER_M, 48'hFFFFFFFF);
                    write_register(REG_Z_SCALE, 48'hFFFF);
                    write_register(REG_Z_FLOOR, 48'h8000);
                    send_idle_pct = 74; recv_stall_pct = 0;
                end
                2: begin
                    write_register(REG_ROT_ROW_X, {16'h8000, 16'h7FFF, 16'hC000});
                    write_register(REG_ROT_ROW_Y, {16'h7FFF, 16'h8000, 16'h4000});
                    write_register(REG_ROT_ROW_Z, {16'h8000, 16'h8000, 16'h8000});
                    write_register(REG_OFFSET_XYZ, {16'h7FFF, 16'h8000, 16'h7FFF});
                    write_register(REG_CELLS_PER_M, 48'd0);
                    write_register(REG_Z_FLOOR, 48'h7FFF);
                    write_register(REG_Z_SCALE, 48'd0);
                    send_idle_pct = 0; recv_stall_pct = 74;
                end
                3: begin
                    write_register(REG_ROT_ROW_X, 48'd16384);
                    write_register(REG_ROT_ROW_Y, 48'd16384 << 16);
                    write_register(REG_ROT_ROW_Z, 48'd16384 << 32);
                    write_register(REG_OFFSET_XYZ, {16'd0, 16'hFC00, 16'd512});
                    write_register(REG_REGION_HALF, 48'h10000800);
                    write_register(REG_CELLS_PER_M, 48'h20001800);
                    write_register(REG_Z_FLOOR, 48'hF000);
                    write_register(REG_Z_SCALE, 48'h0800);
                    send_idle_pct = 38; recv_stall_pct = 38;
                end
                4: begin
                    write_register(REG_ROT_ROW_X, {$urandom, $urandom});
                    write_register(REG_ROT_ROW_Y, {$urandom, $urandom});
                    write_register(REG_ROT_ROW_Z, {$urandom, $urandom});
                    write_register(REG_OFFSET_XYZ, {$urandom, $urandom});
                    write_register(REG_REGION_HALF, 48'h40004000);
                    write_register(REG_Z_SCALE, 48'h0400);
                    send_idle_pct = 0; recv_stall_pct = 0;
                    hold_off_cycles = 400;
                end
                default: begin
                    write_register(REG_ROT_ROW_X, 48'd16384);
                    write_register(REG_ROT_ROW_Y, 48'd16384 << 16);
                    write_register(REG_ROT_ROW_Z, 48'd16384 << 32);
                    write_register(REG_OFFSET_XYZ, 48'd0);
                    write_register(REG_REGION_HALF, 48'h0C000C00);
                    write_register(REG_CELLS_PER_M, 48'd360454656);
                    write_register(REG_Z_FLOOR, 48'hFC00);
                    write_register(REG_Z_SCALE, 48'd2048);
                    send_idle_pct = 20; recv_stall_pct = 20;
                end
            endcase
            n = 180;
            for (int i = 0; i < n; i++) send_request(random_request(25), 0, none);
            wait_idle();
        end

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
